>>> sv/dsp_pkg.sv
// shared types, codes and defaults for the worker slot dispatcher
`default_nettype none

package dsp_pkg;

   localparam int DSP_WORKERS    = 8;
   localparam int DSP_WAIT_SLOTS = 16;

   // configuration register indexes
   localparam logic [1:0] CSR_ACTIVE_WORKERS = 2'd0;
   localparam logic [1:0] CSR_DEPTH_LIMIT    = 2'd1;
   localparam logic [1:0] CSR_LIMIT_DISABLED = 2'd2;

   // result codes
   localparam logic [2:0] OUT_GRANTED   = 3'd0;
   localparam logic [2:0] OUT_QUEUED    = 3'd1;
   localparam logic [2:0] OUT_REJECTED  = 3'd2;
   localparam logic [2:0] OUT_RELEASED  = 3'd3;
   localparam logic [2:0] OUT_HANDED    = 3'd4;
   localparam logic [2:0] OUT_UNDERFLOW = 3'd5;

   typedef enum logic [1:0] {
      CMD_ACQUIRE,
      CMD_RELEASE,
      CMD_RELEASE_BAD
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   tag;
      logic [2:0]   worker;
   } cmd_type;

   typedef struct packed {
      logic [3:0]  active_workers;
      logic [15:0] depth_limit;
      logic        limit_disabled;
   } cfg_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SCAN,
      BK_REL_CHK,
      BK_HAND,
      BK_EMIT
   } back_state_type;

endpackage

`default_nettype wire

>>> sv/dsp_ram.sv
// generic single write port ram with registered read
`default_nettype none

module dsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic                                    rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> sv/dsp_front.sv
// front end: takes items, classifies them and holds them in a two-entry queue
`default_nettype none

module dsp_front
   import dsp_pkg::*;
#(
   parameter int WORKERS = DSP_WORKERS
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_type,
   input  wire logic [7:0] req_requester_tag,
   input  wire logic [2:0] req_release_worker,
   output logic            cmd_valid,
   output cmd_type         cmd,
   input  wire logic       cmd_pop
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   cmd_type    cmd_new;

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = entry_ff[rd_ptr_ff];

   always_comb begin
      cmd_new.tag    = req_requester_tag;
      cmd_new.worker = req_release_worker;
      if (!req_type) begin
         cmd_new.kind = CMD_ACQUIRE;
      end else if (32'(req_release_worker) >= WORKERS) begin
         cmd_new.kind = CMD_RELEASE_BAD;
      end else begin
         cmd_new.kind = CMD_RELEASE;
      end
   end

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? !rd_ptr_ff : rd_ptr_ff;
      case ({push, cmd_pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

`default_nettype wire

>>> sv/dsp_back.sv
// back end: round-robin scan, job counters, waiter queue and result register
`default_nettype none

module dsp_back
   import dsp_pkg::*;
#(
   parameter int WORKERS    = DSP_WORKERS,
   parameter int WAIT_SLOTS = DSP_WAIT_SLOTS
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire logic       cmd_valid,
   input  wire cmd_type    cmd,
   output logic            cmd_pop,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [2:0]      rsp_outcome,
   output logic [2:0]      rsp_worker_index,
   output logic [7:0]      rsp_granted_tag
);

   localparam int WI_W = (WORKERS > 1) ? $clog2(WORKERS) : 1;
   localparam int NW   = $clog2(WORKERS + 1);
   localparam int QI_W = (WAIT_SLOTS > 1) ? $clog2(WAIT_SLOTS) : 1;
   localparam int FL_W = $clog2(WAIT_SLOTS + 1);

   back_state_type   state_ff, state_in;
   logic [WI_W-1:0]  ptr_ff, ptr_in;
   logic [WI_W-1:0]  cur_ff, cur_in;
   logic [NW-1:0]    iter_ff, iter_in;
   logic [QI_W-1:0]  head_ff, head_in;
   logic [QI_W-1:0]  tail_ff, tail_in;
   logic [FL_W-1:0]  fill_ff, fill_in;
   logic [WORKERS-1:0] vld_ff, vld_in;
   logic [7:0]       tag_ff, tag_in;
   logic [2:0]       rel_ff, rel_in;
   logic [2:0]       res_out_ff, res_out_in;
   logic [2:0]       res_idx_ff, res_idx_in;
   logic [7:0]       res_tag_ff, res_tag_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_out_ff, rsp_out_in;
   logic [2:0]       rsp_idx_ff, rsp_idx_in;
   logic [7:0]       rsp_tag_ff, rsp_tag_in;

   logic             cnt_rd_en, cnt_wr_en;
   logic [WI_W-1:0]  cnt_rd_addr, cnt_wr_addr;
   logic [15:0]      cnt_rdata, cnt_wdata;
   logic             wq_rd_en, wq_wr_en;
   logic [7:0]       wq_rdata;

   logic [NW-1:0]    n_act;
   logic [WI_W-1:0]  scan_cur, scan_next;
   logic [15:0]      cnt_cur, cnt_inc;
   logic             fits, fill_any, fill_full, out_free;
   logic [WI_W-1:0]  rel_addr;

   dsp_ram #(.WIDTH(16), .DEPTH(WORKERS)) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wdata),
      .rd_en   (cnt_rd_en),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_rdata)
   );

   dsp_ram #(.WIDTH(8), .DEPTH(WAIT_SLOTS)) u_wait_ram (
      .clock   (clock),
      .wr_en   (wq_wr_en),
      .wr_addr (tail_ff),
      .wr_data (tag_in),
      .rd_en   (wq_rd_en),
      .rd_addr (head_ff),
      .rd_data (wq_rdata)
   );

   // active count clamped into 1..WORKERS
   always_comb begin
      if (cfg.active_workers == 4'd0) begin
         n_act = NW'(1);
      end else if (32'(cfg.active_workers) > WORKERS) begin
         n_act = NW'(WORKERS);
      end else begin
         n_act = NW'(cfg.active_workers);
      end
   end

   assign scan_cur  = (NW'(ptr_ff) < n_act) ? ptr_ff : '0;
   assign scan_next = ((32'(scan_cur) + 1) >= 32'(n_act)) ? '0 : scan_cur + 1'b1;

   // entries never written since reset read as zero
   assign cnt_cur   = vld_ff[cur_ff] ? cnt_rdata : 16'd0;
   assign cnt_inc   = (cnt_cur == 16'hFFFF) ? cnt_cur : cnt_cur + 16'd1;
   assign fits      = cfg.limit_disabled ||
                      (({1'b0, cnt_cur} + 17'd1) <= {1'b0, cfg.depth_limit});
   assign fill_any  = (fill_ff != '0);
   assign fill_full = (fill_ff == FL_W'(WAIT_SLOTS));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rel_addr  = WI_W'(cmd.worker);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               case (cmd.kind)
                  CMD_ACQUIRE: state_in = fill_any ? BK_EMIT : BK_SCAN;
                  CMD_RELEASE: state_in = BK_REL_CHK;
                  default:     state_in = BK_EMIT;
               endcase
            end
         end
         BK_SCAN: begin
            if (fits || (iter_ff == n_act)) begin
               state_in = BK_EMIT;
            end
         end
         BK_REL_CHK: begin
            state_in = ((cnt_cur != 16'd0) && fill_any) ? BK_HAND : BK_EMIT;
         end
         BK_HAND: state_in = BK_EMIT;
         BK_EMIT: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      cmd_pop     = 1'b0;
      ptr_in      = ptr_ff;
      cur_in      = cur_ff;
      iter_in     = iter_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      fill_in     = fill_ff;
      vld_in      = vld_ff;
      tag_in      = tag_ff;
      rel_in      = rel_ff;
      res_out_in  = res_out_ff;
      res_idx_in  = res_idx_ff;
      res_tag_in  = res_tag_ff;
      cnt_rd_en   = 1'b0;
      cnt_rd_addr = scan_cur;
      cnt_wr_en   = 1'b0;
      cnt_wr_addr = cur_ff;
      cnt_wdata   = cnt_inc;
      wq_rd_en    = 1'b0;
      wq_wr_en    = 1'b0;
      rsp_out_in  = rsp_out_ff;
      rsp_idx_in  = rsp_idx_ff;
      rsp_tag_in  = rsp_tag_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               cmd_pop    = 1'b1;
               tag_in     = cmd.tag;
               rel_in     = cmd.worker;
               res_idx_in = 3'd0;
               res_tag_in = 8'd0;
               case (cmd.kind)
                  CMD_ACQUIRE: begin
                     if (fill_any) begin
                        // waiters ahead: join the queue without a scan
                        if (fill_full) begin
                           res_out_in = OUT_REJECTED;
                        end else begin
                           wq_wr_en   = 1'b1;
                           tail_in    = (tail_ff == QI_W'(WAIT_SLOTS - 1)) ?
                                        '0 : tail_ff + 1'b1;
                           fill_in    = fill_ff + 1'b1;
                           res_out_in = OUT_QUEUED;
                        end
                     end else begin
                        cnt_rd_en   = 1'b1;
                        cnt_rd_addr = scan_cur;
                        cur_in      = scan_cur;
                        ptr_in      = scan_next;
                        iter_in     = NW'(1);
                     end
                  end
                  CMD_RELEASE: begin
                     cnt_rd_en   = 1'b1;
                     cnt_rd_addr = rel_addr;
                     cur_in      = rel_addr;
                  end
                  default: begin
                     res_out_in = OUT_UNDERFLOW;
                     res_idx_in = cmd.worker;
                  end
               endcase
            end
         end
         BK_SCAN: begin
            if (fits) begin
               cnt_wr_en      = 1'b1;
               cnt_wdata      = cnt_inc;
               vld_in[cur_ff] = 1'b1;
               res_out_in     = OUT_GRANTED;
               res_idx_in     = 3'(cur_ff);
               res_tag_in     = tag_ff;
            end else if (iter_ff == n_act) begin
               // every active worker is full: wait in the queue
               if (fill_full) begin
                  res_out_in = OUT_REJECTED;
               end else begin
                  wq_wr_en   = 1'b1;
                  tail_in    = (tail_ff == QI_W'(WAIT_SLOTS - 1)) ?
                               '0 : tail_ff + 1'b1;
                  fill_in    = fill_ff + 1'b1;
                  res_out_in = OUT_QUEUED;
               end
            end else begin
               cnt_rd_en   = 1'b1;
               cnt_rd_addr = scan_cur;
               cur_in      = scan_cur;
               ptr_in      = scan_next;
               iter_in     = iter_ff + 1'b1;
            end
         end
         BK_REL_CHK: begin
            res_idx_in = rel_ff;
            res_tag_in = 8'd0;
            if (cnt_cur == 16'd0) begin
               res_out_in = OUT_UNDERFLOW;
            end else if (fill_any) begin
               // handoff: the count stays as it is
               wq_rd_en   = 1'b1;
               head_in    = (head_ff == QI_W'(WAIT_SLOTS - 1)) ? '0 : head_ff + 1'b1;
               fill_in    = fill_ff - 1'b1;
               res_out_in = OUT_HANDED;
            end else begin
               cnt_wr_en      = 1'b1;
               cnt_wdata      = cnt_cur - 16'd1;
               vld_in[cur_ff] = 1'b1;
               res_out_in     = OUT_RELEASED;
            end
         end
         BK_HAND: begin
            res_tag_in = wq_rdata;
         end
         BK_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_out_in   = res_out_ff;
               rsp_idx_in   = res_idx_ff;
               rsp_tag_in   = res_tag_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         ptr_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      iter_ff    <= iter_in;
      tag_ff     <= tag_in;
      rel_ff     <= rel_in;
      res_out_ff <= res_out_in;
      res_idx_ff <= res_idx_in;
      res_tag_ff <= res_tag_in;
      rsp_out_ff <= rsp_out_in;
      rsp_idx_ff <= rsp_idx_in;
      rsp_tag_ff <= rsp_tag_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_outcome      = rsp_out_ff;
   assign rsp_worker_index = rsp_idx_ff;
   assign rsp_granted_tag  = rsp_tag_ff;

endmodule

`default_nettype wire

>>> sv/worker_slot_dispatcher.sv
// top level of the worker slot dispatcher: config registers, front end and back end
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_type, req_requester_tag, req_release_worker
//   rsp      out        rsp_valid/rsp_stall  rsp_outcome, rsp_worker_index, rsp_granted_tag
//   csr      in         csr_write_enable     csr_index, csr_write_data
//
// an acquire with no waiters scans the active workers round-robin, one counter read per
// cycle from the count ram; an acquire behind waiters and a bad-index release go straight
// to the result register, releases pass through a check and handoffs also through a queue read.
// the back end runs one item at a time; the front queue holds two more.
// synchronous reset clears counters (through per-worker valid bits) and queue pointers.
// a stalled result stays in the output register while the front keeps taking items until its queue is full.
`default_nettype none

module worker_slot_dispatcher
   import dsp_pkg::*;
#(
   parameter int WORKERS    = DSP_WORKERS,
   parameter int WAIT_SLOTS = DSP_WAIT_SLOTS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_type,
   input  wire logic [7:0]  req_requester_tag,
   input  wire logic [2:0]  req_release_worker,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_outcome,
   output logic [2:0]       rsp_worker_index,
   output logic [7:0]       rsp_granted_tag,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_write_data
);

   cfg_type cfg_ff, cfg_in;
   logic    cmd_valid, cmd_pop;
   cmd_type cmd;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_ACTIVE_WORKERS: cfg_in.active_workers = csr_write_data[3:0];
            CSR_DEPTH_LIMIT:    cfg_in.depth_limit    = csr_write_data;
            CSR_LIMIT_DISABLED: cfg_in.limit_disabled = csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_workers <= 4'd8;
         cfg_ff.depth_limit    <= 16'd16;
         cfg_ff.limit_disabled <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dsp_front #(.WORKERS(WORKERS)) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_requester_tag  (req_requester_tag),
      .req_release_worker (req_release_worker),
      .cmd_valid          (cmd_valid),
      .cmd                (cmd),
      .cmd_pop            (cmd_pop)
   );

   dsp_back #(.WORKERS(WORKERS), .WAIT_SLOTS(WAIT_SLOTS)) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_outcome      (rsp_outcome),
      .rsp_worker_index (rsp_worker_index),
      .rsp_granted_tag  (rsp_granted_tag)
   );

endmodule

`default_nettype wire

>>> sv/dsp_checker.sv
// port-level checks on the dispatcher's result channel, bound to the top level
`default_nettype none

module dsp_checker
   import dsp_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [2:0] rsp_outcome,
   input wire logic [2:0] rsp_worker_index,
   input wire logic [7:0] rsp_granted_tag
);

   // a held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_outcome) &&
      $stable(rsp_worker_index) && $stable(rsp_granted_tag))
      else $error("result changed while stalled");

   a_rsp_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_outcome <= OUT_UNDERFLOW))
      else $error("result code out of range");

   // only grants and handoffs name a requester
   a_tag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_outcome == OUT_QUEUED || rsp_outcome == OUT_REJECTED ||
      rsp_outcome == OUT_RELEASED || rsp_outcome == OUT_UNDERFLOW)
      |-> (rsp_granted_tag == 8'd0))
      else $error("tag present on a result without a requester");

   a_idx_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_outcome == OUT_QUEUED || rsp_outcome == OUT_REJECTED)
      |-> (rsp_worker_index == 3'd0))
      else $error("worker index on a queued or rejected item");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind worker_slot_dispatcher dsp_checker u_dsp_checker (.*);

`default_nettype wire
